FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the filename packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RX50_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RX50_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rx50_pkg.sv
// Types, constants and helper functions of the RADIX-50 filename packer.
package rx50_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [15:0] name_word_a;
    logic [15:0] name_word_b;
    logic [15:0] ext_word;
    logic [1:0]  status;
  } out_t;

  // Status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadChar = 2'd1;
  localparam logic [1:0] StatusTooLong = 2'd2;

  localparam int unsigned NameMaxChars = 6;
  localparam int unsigned ExtMaxChars  = 3;
  localparam int unsigned Weight0      = 40 * 40;
  localparam int unsigned Weight1      = 40;

  localparam logic [5:0] CodeInvalid = 6'd40;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5a;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7a;

  // ASCII to RADIX-50 code, lower case folded; CodeInvalid for anything else.
  function automatic logic [5:0] char_to_code(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] diff;
    u = c;
    if (c >= ChLowerA && c <= ChLowerZ) begin
      u = c - (ChLowerA - ChUpperA);
    end
    diff = 8'd0;
    priority if (u == ChSpace) begin
      return 6'd0;
    end else if (u >= ChUpperA && u <= ChUpperZ) begin
      diff = u - (ChUpperA - 8'd1);
      return diff[5:0];
    end else if (u == ChDollar) begin
      return 6'd27;
    end else if (u == ChDot) begin
      return 6'd28;
    end else if (u == ChPercent) begin
      return 6'd29;
    end else if (u >= ChZero && u <= ChNine) begin
      diff = u - (ChZero - 8'd30);
      return diff[5:0];
    end else begin
      return CodeInvalid;
    end
  endfunction

  // Weighted contribution of a code at slot 0, 1 or 2 of a word.
  function automatic logic [15:0] slot_term(input logic [5:0] code, input logic [1:0] slot);
    logic [15:0] t;
    unique case (slot)
      2'd0:    t = 16'(code) * 16'(Weight0);
      2'd1:    t = 16'(code) * 16'(Weight1);
      default: t = 16'(code);
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/rx50_core.sv
// Per-character packing state and its combinational update.
`include "assert_macros.svh"

module rx50_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  rx50_pkg::in_t    data_i,
  output rx50_pkg::out_t   res_o
);

  logic [15:0] acc_a_q, acc_a_d;
  logic [15:0] acc_b_q, acc_b_d;
  logic [15:0] acc_e_q, acc_e_d;
  logic [2:0]  pos_q, pos_d;
  logic        ext_q, ext_d;
  logic [1:0]  err_q, err_d;

  logic [5:0]  code;
  logic [2:0]  pos_hi;
  logic [1:0]  slot;
  logic [15:0] term;
  logic        full;

  always_comb begin
    code   = rx50_pkg::char_to_code(data_i.char_code);
    pos_hi = pos_q - 3'd3;
    slot   = (ext_q || pos_q < 3'd3) ? pos_q[1:0] : pos_hi[1:0];
    term   = rx50_pkg::slot_term(code, slot);
    full   = ext_q ? (pos_q >= 3'(rx50_pkg::ExtMaxChars))
                   : (pos_q >= 3'(rx50_pkg::NameMaxChars));

    acc_a_d = acc_a_q;
    acc_b_d = acc_b_q;
    acc_e_d = acc_e_q;
    pos_d   = pos_q;
    ext_d   = ext_q;
    err_d   = err_q;

    // first error sticks, later characters are dropped
    priority if (err_q != rx50_pkg::StatusOk) begin
      err_d = err_q;
    end else if (!ext_q && data_i.char_code == rx50_pkg::ChDot) begin
      ext_d = 1'b1;
      pos_d = 3'd0;
    end else if (full) begin
      err_d = rx50_pkg::StatusTooLong;
    end else if (code == rx50_pkg::CodeInvalid) begin
      err_d = rx50_pkg::StatusBadChar;
    end else begin
      if (ext_q) begin
        acc_e_d = acc_e_q + term;
      end else if (pos_q < 3'd3) begin
        acc_a_d = acc_a_q + term;
      end else begin
        acc_b_d = acc_b_q + term;
      end
      pos_d = pos_q + 3'd1;
    end

    // result reflects this character's update
    res_o.status = err_d;
    if (err_d != rx50_pkg::StatusOk) begin
      res_o.name_word_a = 16'd0;
      res_o.name_word_b = 16'd0;
      res_o.ext_word    = 16'd0;
    end else begin
      res_o.name_word_a = acc_a_d;
      res_o.name_word_b = acc_b_d;
      res_o.ext_word    = acc_e_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_a_q <= 16'd0;
      acc_b_q <= 16'd0;
      acc_e_q <= 16'd0;
      pos_q   <= 3'd0;
      ext_q   <= 1'b0;
      err_q   <= rx50_pkg::StatusOk;
    end else if (step_i) begin
      if (data_i.last_char) begin
        acc_a_q <= 16'd0;
        acc_b_q <= 16'd0;
        acc_e_q <= 16'd0;
        pos_q   <= 3'd0;
        ext_q   <= 1'b0;
        err_q   <= rx50_pkg::StatusOk;
      end else begin
        acc_a_q <= acc_a_d;
        acc_b_q <= acc_b_d;
        acc_e_q <= acc_e_d;
        pos_q   <= pos_d;
        ext_q   <= ext_d;
        err_q   <= err_d;
      end
    end
  end

  `RX50_ASSERT_NXT(a_clear_after_last, step_i && data_i.last_char,
                   pos_q == 3'd0 && !ext_q && err_q == rx50_pkg::StatusOk,
                   "state not cleared after last character")
  `RX50_ASSERT_NXT(a_err_sticky, err_q != rx50_pkg::StatusOk && !(step_i && data_i.last_char),
                   err_q == $past(err_q) && acc_a_q == $past(acc_a_q),
                   "sticky error or accumulator changed")
  `RX50_ASSERT_IMP(a_name_pos, !ext_q, pos_q <= 3'(rx50_pkg::NameMaxChars),
                   "name position out of range")
  `RX50_ASSERT_IMP(a_ext_pos, ext_q, pos_q <= 3'(rx50_pkg::ExtMaxChars),
                   "extension position out of range")

endmodule

FILE: hw/rtl/radix50_filename_packer.sv
// A result is registered when its last character leaves the input register.
// Throughput: one character per cycle; the input register feeds the packing
//   step, and the result register decouples the output stall.
// A last character waits in the input register only while the result register
//   is full and stalled; other characters never wait.
// Reset (rst_ni low, async): both registers empty, packing state cleared.
`include "assert_macros.svh"

module radix50_filename_packer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rx50_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rx50_pkg::out_t out_data_o
);

  // input register
  logic          in_valid_q, in_valid_d;
  rx50_pkg::in_t in_q;

  // result register
  logic           out_valid_q, out_valid_d;
  rx50_pkg::out_t out_q;

  rx50_pkg::out_t res;
  logic           out_free;
  logic           advance;
  logic           in_xfer;

  // A non-final character never needs the result register; a final one does.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!in_q.last_char || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  rx50_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .data_i (in_q),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance && in_q.last_char) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (advance && in_q.last_char) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RX50_ASSERT_IMP(a_err_zero_words, out_valid_o && out_data_o.status != rx50_pkg::StatusOk,
                   out_data_o.name_word_a == 16'd0 && out_data_o.name_word_b == 16'd0
                   && out_data_o.ext_word == 16'd0,
                   "error result carries nonzero words")
  `RX50_ASSERT_IMP(a_last_blocked, in_valid_q && in_q.last_char && out_valid_q && out_stall_i,
                   in_stall_o && !advance,
                   "final character passed a full stalled result register")
  `RX50_ASSERT_IMP(a_stall_needs_item, in_stall_o, in_valid_q && in_q.last_char,
                   "input stalled without a waiting final character")

endmodule

FILE: bench/tb_radix50_filename_packer.sv
// Self-checking testbench for the RADIX-50 filename packer.
module tb_radix50_filename_packer;
  timeunit 1ns;
  timeprecision 1ps;

  // Random characters to send after the directed table.
  localparam int unsigned RandomChars  = 1700;
  // Cycles without any transfer on either side before the run is abandoned.
  localparam int unsigned QuietLimit   = 4000;
  // Slack after the drain, so that a stray extra result can still show up.
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned MaxReported  = 10;

  // One row of the directed table. Where typed is set, word is the expected
  // result; every other row leans on the packing model below.
  typedef struct packed {
    logic [7:0]     ch;
    logic           last;
    logic           typed;
    rx50_pkg::out_t word;
  } step_t;

  localparam rx50_pkg::out_t NoWord   = '0;
  localparam rx50_pkg::out_t MaxWord  = '{16'd63999, 16'd63999, 16'd63999,
                                          rx50_pkg::StatusOk};
  localparam rx50_pkg::out_t BadWord  = '{16'd0, 16'd0, 16'd0, rx50_pkg::StatusBadChar};
  localparam rx50_pkg::out_t LongWord = '{16'd0, 16'd0, 16'd0, rx50_pkg::StatusTooLong};

  localparam int unsigned DirCount = 25;
  localparam step_t DirSteps [DirCount] = '{
    // NUL alone is an invalid character
    '{8'h00, 1'b1, 1'b1, BadWord},
    // highest code in all nine slots; the seventh character is the dot
    '{"9", 1'b0, 1'b0, NoWord},
    '{"9", 1'b0, 1'b0, NoWord},
    '{"9", 1'b0, 1'b0, NoWord},
    '{"9", 1'b0, 1'b0, NoWord},
    '{"9", 1'b0, 1'b0, NoWord},
    '{"9", 1'b0, 1'b0, NoWord},
    '{".", 1'b0, 1'b0, NoWord},
    '{"9", 1'b0, 1'b0, NoWord},
    '{"9", 1'b0, 1'b0, NoWord},
    '{"9", 1'b1, 1'b1, MaxWord},
    // seventh name character not a dot; the length check beats the bad '/'
    '{"z", 1'b0, 1'b0, NoWord},
    '{"A", 1'b0, 1'b0, NoWord},
    '{" ", 1'b0, 1'b0, NoWord},
    '{"$", 1'b0, 1'b0, NoWord},
    '{"%", 1'b0, 1'b0, NoWord},
    '{"0", 1'b0, 1'b0, NoWord},
    '{"/", 1'b1, 1'b1, LongWord},
    // empty name, dot inside the extension, then a fourth extension char
    '{".", 1'b0, 1'b0, NoWord},
    '{"a", 1'b0, 1'b0, NoWord},
    '{".", 1'b0, 1'b0, NoWord},
    '{"$", 1'b0, 1'b0, NoWord},
    '{"%", 1'b1, 1'b1, LongWord},
    // code 255 is invalid and sticks; the dot after it changes nothing
    '{8'hff, 1'b0, 1'b0, NoWord},
    '{".", 1'b1, 1'b1, BadWord}
  };

  logic           clk_i;
  logic           rst_ni       = 1'b0;
  logic           in_valid_i   = 1'b0;
  logic           in_stall_o;
  rx50_pkg::in_t  in_data_i    = '0;
  logic           out_valid_o;
  logic           out_stall_i  = 1'b0;
  rx50_pkg::out_t out_data_o;

  radix50_filename_packer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Idle mix, in percent of cycles: sender gaps and receiver stalls.
  int unsigned tx_idle_pct  = 8;
  int unsigned rx_stall_pct = 75;

  // Packing model state: partial words, slot counter, phase, sticky status.
  logic [15:0] name_a_sum;
  logic [15:0] name_b_sum;
  logic [15:0] ext_sum;
  logic [2:0]  slot_count;
  logic        in_ext;
  logic [1:0]  sticky_status;

  // Packed words still to come out of the block, oldest first.
  rx50_pkg::out_t packed_words_q [$];

  int unsigned chars_sent;
  int unsigned results_checked;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned status_seen [4];

  initial begin
    name_a_sum    = '0;
    name_b_sum    = '0;
    ext_sum       = '0;
    slot_count    = '0;
    in_ext        = 1'b0;
    sticky_status = rx50_pkg::StatusOk;
  end

  // RADIX-50 code of one byte, lower case folded; CodeInvalid otherwise.
  function automatic logic [5:0] rx50_code_of(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= rx50_pkg::ChLowerA && ch <= rx50_pkg::ChLowerZ)
         ? ch - (rx50_pkg::ChLowerA - rx50_pkg::ChUpperA) : ch;
    if (up == rx50_pkg::ChSpace) return 6'd0;
    if (up >= rx50_pkg::ChUpperA && up <= rx50_pkg::ChUpperZ)
      return 6'(up - rx50_pkg::ChUpperA + 8'd1);
    if (up == rx50_pkg::ChDollar) return 6'd27;
    if (up == rx50_pkg::ChDot) return 6'd28;
    if (up == rx50_pkg::ChPercent) return 6'd29;
    if (up >= rx50_pkg::ChZero && up <= rx50_pkg::ChNine)
      return 6'(up - rx50_pkg::ChZero + 8'd30);
    return rx50_pkg::CodeInvalid;
  endfunction

  // Feeds one accepted character to the model. On the last character the
  // finished words come back in word and the model clears itself.
  task automatic pack_char(input rx50_pkg::in_t item, output bit done,
                           output rx50_pkg::out_t word);
    logic [5:0]  code;
    logic [2:0]  slot;
    logic [15:0] term;
    done = item.last_char;
    word = '0;
    if (sticky_status == rx50_pkg::StatusOk) begin
      if (!in_ext && item.char_code == rx50_pkg::ChDot) begin
        // the dot only switches phase, it is not stored
        in_ext     = 1'b1;
        slot_count = '0;
      end else if (slot_count >= (in_ext ? rx50_pkg::ExtMaxChars
                                         : rx50_pkg::NameMaxChars)) begin
        sticky_status = rx50_pkg::StatusTooLong;
      end else begin
        code = rx50_code_of(item.char_code);
        if (code == rx50_pkg::CodeInvalid) begin
          sticky_status = rx50_pkg::StatusBadChar;
        end else begin
          slot = (!in_ext && slot_count >= 3) ? slot_count - 3'd3 : slot_count;
          case (slot)
            3'd0:    term = 16'(code) * 16'(rx50_pkg::Weight0);
            3'd1:    term = 16'(code) * 16'(rx50_pkg::Weight1);
            default: term = 16'(code);
          endcase
          if (in_ext) begin
            ext_sum = ext_sum + term;
          end else if (slot_count < 3) begin
            name_a_sum = name_a_sum + term;
          end else begin
            name_b_sum = name_b_sum + term;
          end
          slot_count = slot_count + 3'd1;
        end
      end
    end
    if (done) begin
      word.status = sticky_status;
      if (sticky_status == rx50_pkg::StatusOk) begin
        word.name_word_a = name_a_sum;
        word.name_word_b = name_b_sum;
        word.ext_word    = ext_sum;
      end
      name_a_sum    = '0;
      name_b_sum    = '0;
      ext_sum       = '0;
      slot_count    = '0;
      in_ext        = 1'b0;
      sticky_status = rx50_pkg::StatusOk;
    end
  endtask

  // Counts a failure; only the first few get a line of their own.
  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) $display("mismatch %0d: %s", fail_count, msg);
  endfunction

  // One character over the input channel. Random gaps come first; once
  // valid is up, the payload holds until the transfer. The model sees the
  // character in the same step as the accepting edge.
  task automatic send_char(input logic [7:0] ch, input logic last, input bit typed,
                           input rx50_pkg::out_t typed_word);
    rx50_pkg::in_t  item;
    bit             done;
    rx50_pkg::out_t word;
    item.char_code = ch;
    item.last_char = last;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    pack_char(item, done, word);
    if (done) packed_words_q = {packed_words_q, (typed ? typed_word : word)};
  endtask

  // Any legal character; the dot only where it is an ordinary character.
  function automatic logic [7:0] pick_rx50_char(input bit dot_ok);
    int unsigned idx;
    idx = $urandom_range(39);
    if (!dot_ok && idx == 28) idx = $urandom_range(27);
    if (idx == 0) return rx50_pkg::ChSpace;
    if (idx <= 26)
      return 8'(idx - 1) + ($urandom_range(1) ? rx50_pkg::ChLowerA : rx50_pkg::ChUpperA);
    if (idx == 27) return rx50_pkg::ChDollar;
    if (idx == 28) return rx50_pkg::ChDot;
    if (idx == 29) return rx50_pkg::ChPercent;
    return 8'(idx - 30) + rx50_pkg::ChZero;
  endfunction

  // One random filename. Mostly well-formed names with random content and
  // random name/extension lengths; the rest overlong layouts, names with one
  // bad byte, and raw byte noise.
  task automatic send_filename();
    logic [7:0]  text [$];
    logic [7:0]  bad;
    int unsigned form;
    int unsigned name_len;
    int unsigned ext_len;
    int unsigned spot;
    bit          has_dot;
    form = $urandom_range(99);
    if (form >= 90) begin
      repeat ($urandom_range(9, 1)) text = {text, 8'($urandom_range(255))};
    end else begin
      name_len = $urandom_range(6);
      has_dot  = (name_len == 0) || ($urandom_range(1) == 1);
      ext_len  = has_dot ? $urandom_range(3) : 0;
      if (form >= 70 && form < 80) begin
        // too long: either the extension or the name overflows
        if (has_dot && $urandom_range(1) == 1) ext_len = $urandom_range(5, 4);
        else name_len = $urandom_range(8, 7);
      end
      repeat (name_len) text = {text, pick_rx50_char(1'b0)};
      if (has_dot) text = {text, rx50_pkg::ChDot};
      repeat (ext_len) text = {text, pick_rx50_char(1'b1)};
      if (form >= 80) begin
        do bad = 8'($urandom_range(255)); while (rx50_code_of(bad) != rx50_pkg::CodeInvalid);
        spot       = $urandom_range(text.size() - 1);
        text[spot] = bad;
      end
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, NoWord);
  endtask

  // Receiver: random stalls at the rate of the current idle mix.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // Result checker and watchdog. Both look at values from before the edge,
  // since every input is driven with nonblocking assignments.
  always @(posedge clk_i) begin
    rx50_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (packed_words_q.size() == 0) begin
          flag_error($sformatf("result %0d/%0d/%0d status %0d with none expected",
                               out_data_o.name_word_a, out_data_o.name_word_b,
                               out_data_o.ext_word, out_data_o.status));
        end else begin
          want = packed_words_q.pop_front();
          results_checked++;
          status_seen[want.status]++;
          if (out_data_o.name_word_a !== want.name_word_a ||
              out_data_o.name_word_b !== want.name_word_b ||
              out_data_o.ext_word !== want.ext_word ||
              out_data_o.status !== want.status) begin
            flag_error($sformatf("expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
                                 want.name_word_a, want.name_word_b, want.ext_word,
                                 want.status, out_data_o.name_word_a,
                                 out_data_o.name_word_b, out_data_o.ext_word,
                                 out_data_o.status));
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                   quiet_cycles, packed_words_q.size());
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table under the first idle mix.
    for (int i = 0; i < DirCount; i++) begin
      send_char(DirSteps[i].ch, DirSteps[i].last, DirSteps[i].typed, DirSteps[i].word);
    end

    // Random filenames; the idle mix moves on every third of the characters.
    while (chars_sent < DirCount + RandomChars) begin
      if (chars_sent >= DirCount + 2 * RandomChars / 3) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end else if (chars_sent >= DirCount + RandomChars / 3) begin
        tx_idle_pct  = 75;
        rx_stall_pct = 8;
      end
      send_filename();
    end
    in_valid_i <= 1'b0;

    // Drain, then give a stray extra result time to show up.
    while (packed_words_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("summary: %0d characters sent, %0d packed results checked (%0d ok, %0d bad char, %0d too long)",
             chars_sent, results_checked, status_seen[rx50_pkg::StatusOk],
             status_seen[rx50_pkg::StatusBadChar], status_seen[rx50_pkg::StatusTooLong]);
    $display("summary: idle mixes sender/receiver 8/75, 75/8 and 0/0 percent, %0d mismatches",
             fail_count);
    if (fail_count == 0 && packed_words_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
